// File: rtl/core/swdht_pkg.sv
package swdht_pkg;

  typedef logic [2:0] status_t;

  localparam status_t StatusOk       = 3'd0;
  localparam status_t StatusFault    = 3'd1;
  localparam status_t StatusTimeout  = 3'd2;
  localparam status_t StatusProtocol = 3'd3;
  localparam status_t StatusParity   = 3'd4;

  // acknowledge codes as sampled, LSB first
  localparam logic [2:0] AckOk    = 3'b001;
  localparam logic [2:0] AckWait  = 3'b010;
  localparam logic [2:0] AckFault = 3'b100;

  localparam logic [7:0] ReqBase   = 8'h81;  // start and park bits
  localparam logic [7:0] ReqApBit  = 8'h02;
  localparam logic [7:0] ReqRnwBit = 8'h04;
  localparam logic [7:0] ReqParBit = 8'h20;
  localparam logic [7:0] ReqAddrMask = 8'h0c;

  localparam logic [3:0] MaxTriesReset = 4'd4;
  localparam int unsigned AckBits  = 3;
  localparam int unsigned ReadBits = 33;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_ACK  = 3'b010,
    PH_READ = 3'b100
  } phase_e;

  typedef enum logic [3:0] {
    EM_IDLE  = 4'b0001,
    EM_REQ   = 4'b0010,
    EM_WDATA = 4'b0100,
    EM_FIN   = 4'b1000
  } emit_e;

endpackage

// File: rtl/core/swd_host_transaction.sv
// Host side of one serial-wire-debug transaction. Input beats are either a start (port,
// direction, A[3:2], write word) or one sampled wire bit; output beats are either a bit
// to drive or a finish with status and read word. Sampled bits that produce no output
// are taken one per cycle, back to back. An item that produces output loads a burst
// emitter which fills the output register at one beat per cycle whenever the output
// is not stalled: a request is 8 beats, a successful write 34 (32 data bits, parity,
// finish), any finish 1. While the emitter drains, in_stall_o is high, so an item
// that causes a burst holds off further input until its burst has drained. The output
// register lets a new item in while an earlier beat still waits to be taken. max_tries
// is written through the cfg channel, which is always ready.
module swd_host_transaction (
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [3:0]               cfg_data_i,

  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     req_type_i,
  input  logic                     access_port_i,
  input  logic                     read_not_write_i,
  input  logic [1:0]               reg_select_i,
  input  logic [31:0]              write_data_i,
  input  logic                     wire_bit_i,

  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     kind_o,
  output logic                     drive_bit_o,
  output logic                     last_bit_o,
  output swdht_pkg::status_t       status_o,
  output logic [31:0]              read_data_o
);
  import swdht_pkg::*;

  logic [3:0]  max_tries_q;
  phase_e      phase_q, phase_d;
  logic [5:0]  bit_count_q, bit_count_d;
  logic [32:0] shift_q, shift_d;
  logic [3:0]  tries_q, tries_d;
  logic [7:0]  req_byte_q, req_byte_d;
  logic [31:0] wword_q, wword_d;
  logic        dir_q, dir_d;

  emit_e       em_q, em_d;
  logic [5:0]  em_idx_q, em_idx_d;
  status_t     em_status_q, em_status_d;
  logic [31:0] em_data_q, em_data_d;

  logic        out_valid_q, out_valid_d;
  logic        kind_q, kind_d;
  logic        drv_q, drv_d;
  logic        last_q, last_d;
  status_t     status_q, status_d;
  logic [31:0] rdata_q, rdata_d;

  logic        in_accept;
  logic        out_free;
  logic [32:0] shift_in;
  logic [2:0]  ack;
  logic [7:0]  req_calc;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (em_q != EM_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign shift_in = {wire_bit_i, shift_q[32:1]};
  // first sampled bit sits at [31], second at [32], third is on the wire now
  assign ack      = {wire_bit_i, shift_q[32], shift_q[31]};

  always_comb begin
    // A[3:2] sits one place up in the request byte
    req_calc = ReqBase | ((ReqAddrMask & {4'b0000, reg_select_i, 2'b00}) << 1);
    if (access_port_i) req_calc = req_calc | ReqApBit;
    if (read_not_write_i) req_calc = req_calc | ReqRnwBit;
    if (access_port_i ^ read_not_write_i ^ reg_select_i[0] ^ reg_select_i[1]) begin
      req_calc = req_calc | ReqParBit;
    end
  end

  // transaction state and burst loading
  always_comb begin
    phase_d     = phase_q;
    bit_count_d = bit_count_q;
    shift_d     = shift_q;
    tries_d     = tries_q;
    req_byte_d  = req_byte_q;
    wword_d     = wword_q;
    dir_d       = dir_q;
    em_d        = em_q;
    em_idx_d    = em_idx_q;
    em_status_d = em_status_q;
    em_data_d   = em_data_q;

    // emitter advances one beat whenever the output register can take it
    if (em_q != EM_IDLE && out_free) begin
      unique case (em_q)
        EM_REQ: begin
          em_idx_d = em_idx_q + 6'd1;
          if (em_idx_q[2:0] == 3'd7) em_d = EM_IDLE;
        end
        EM_WDATA: begin
          em_idx_d = em_idx_q + 6'd1;
          if (em_idx_q[5]) begin
            em_d        = EM_FIN;
            em_status_d = StatusOk;
            em_data_d   = '0;
          end
        end
        EM_FIN: em_d = EM_IDLE;
        default: em_d = EM_IDLE;
      endcase
    end

    if (in_accept) begin
      em_idx_d = '0;
      if (!req_type_i) begin
        req_byte_d  = req_calc;
        dir_d       = read_not_write_i;
        wword_d     = write_data_i;
        tries_d     = 4'd1;
        phase_d     = PH_ACK;
        bit_count_d = '0;
        shift_d     = '0;
        em_d        = EM_REQ;
      end else begin
        unique case (phase_q)
          PH_ACK: begin
            shift_d     = shift_in;
            bit_count_d = bit_count_q + 6'd1;
            if (bit_count_q == 6'(AckBits - 1)) begin
              bit_count_d = '0;
              shift_d     = '0;
              em_data_d   = '0;
              if (ack == AckOk) begin
                if (dir_q) begin
                  phase_d = PH_READ;
                end else begin
                  phase_d = PH_IDLE;
                  em_d    = EM_WDATA;
                end
              end else if (ack == AckWait) begin
                if (tries_q >= max_tries_q) begin
                  phase_d     = PH_IDLE;
                  em_d        = EM_FIN;
                  em_status_d = StatusTimeout;
                end else begin
                  tries_d = tries_q + 4'd1;
                  em_d    = EM_REQ;
                end
              end else begin
                phase_d     = PH_IDLE;
                em_d        = EM_FIN;
                em_status_d = (ack == AckFault) ? StatusFault : StatusProtocol;
              end
            end
          end
          PH_READ: begin
            shift_d     = shift_in;
            bit_count_d = bit_count_q + 6'd1;
            if (bit_count_q == 6'(ReadBits - 1)) begin
              phase_d     = PH_IDLE;
              bit_count_d = '0;
              shift_d     = '0;
              em_d        = EM_FIN;
              if (^shift_in) begin
                em_status_d = StatusParity;
                em_data_d   = '0;
              end else begin
                em_status_d = StatusOk;
                em_data_d   = shift_in[31:0];
              end
            end
          end
          PH_IDLE: ;
          default: ;
        endcase
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    drv_d       = drv_q;
    last_d      = last_q;
    status_d    = status_q;
    rdata_d     = rdata_q;
    if (out_free) begin
      out_valid_d = (em_q != EM_IDLE);
      kind_d      = 1'b0;
      drv_d       = 1'b0;
      last_d      = 1'b0;
      status_d    = StatusOk;
      rdata_d     = '0;
      unique case (em_q)
        EM_REQ: begin
          drv_d  = req_byte_q[em_idx_q[2:0]];
          last_d = (em_idx_q[2:0] == 3'd7);
        end
        EM_WDATA: begin
          if (em_idx_q[5]) begin
            drv_d  = ^wword_q;
            last_d = 1'b1;
          end else begin
            drv_d = wword_q[em_idx_q[4:0]];
          end
        end
        EM_FIN: begin
          kind_d   = 1'b1;
          status_d = em_status_q;
          rdata_d  = em_data_q;
        end
        EM_IDLE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tries_q <= MaxTriesReset;
      phase_q     <= PH_IDLE;
      bit_count_q <= '0;
      shift_q     <= '0;
      tries_q     <= '0;
      req_byte_q  <= '0;
      wword_q     <= '0;
      dir_q       <= 1'b0;
      em_q        <= EM_IDLE;
      em_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) max_tries_q <= cfg_data_i;
      phase_q     <= phase_d;
      bit_count_q <= bit_count_d;
      shift_q     <= shift_d;
      tries_q     <= tries_d;
      req_byte_q  <= req_byte_d;
      wword_q     <= wword_d;
      dir_q       <= dir_d;
      em_q        <= em_d;
      em_idx_q    <= em_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    em_status_q <= em_status_d;
    em_data_q   <= em_data_d;
    kind_q      <= kind_d;
    drv_q       <= drv_d;
    last_q      <= last_d;
    status_q    <= status_d;
    rdata_q     <= rdata_d;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign drive_bit_o = drv_q;
  assign last_bit_o  = last_q;
  assign status_o    = status_q;
  assign read_data_o = rdata_q;

endmodule
